[design/riff_wave_chunk_locator_unit_assert.svh]
// assertion macros shared by the chunk locator rtl
// needs nothing else; include inside a module body after its signals
`ifndef RIFF_WAVE_CHUNK_LOCATOR_UNIT_ASSERT_SVH
`define RIFF_WAVE_CHUNK_LOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is high
`define RWCL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define RWCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/rwcl_pkg.sv]
// types and constants for the riff/wave chunk locator
// no dependencies; imported by riff_wave_chunk_locator_unit
package rwcl_pkg;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       last_byte;
   } rwcl_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] format_offset;
      logic [31:0] data_offset;
      logic [31:0] data_length;
   } rwcl_rsp_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TAG,
      PH_LEN,
      PH_SKIP,
      PH_DONE
   } rwcl_phase_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
   localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
   localparam logic [2:0] ST_FMT_SHORT = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // tags as gathered little-endian
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_MIN_LEN = 32'd14;

   localparam logic [32:0] POS_RIFF_TAG  = 33'd3;
   localparam logic [32:0] POS_RIFF_LEN  = 33'd7;
   localparam logic [32:0] POS_WAVE_TAG  = 33'd11;
   localparam logic [32:0] POS_FIRST_CHK = 33'd12;
   localparam logic [32:0] HDR_FIELD_LEN = 33'd4;

endpackage

[design/riff_wave_chunk_locator_unit.sv]
// riff/wave chunk locator: one file byte per word, one status word per file
// depends on rwcl_pkg and riff_wave_chunk_locator_unit_assert.svh
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/stall    | file_byte, last_byte
//  rsp     | out | rsp_valid/stall    | status, format_offset, data_offset, data_length
//  csr     | in  | csr_valid/ready    | want_format
//
// one byte per cycle while req_stall is low; a status word is registered the cycle after the byte that decides it
// the parse state updates in the accepting cycle, so bytes may follow back to back
// req_stall rises only while a status word sits in the output register under rsp_stall
// synchronous reset clears all parse state and sets want_format; csr_ready is always high
module riff_wave_chunk_locator_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rwcl_pkg::rwcl_req_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rwcl_pkg::rwcl_rsp_type  rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_data
);
   import rwcl_pkg::*;

   rwcl_phase_type phase_ff, phase_in;
   logic [32:0]    pos_ff, pos_in;
   logic [31:0]    gather_ff, gather_in;
   logic [31:0]    tag_ff, tag_in;
   logic [32:0]    endm1_ff, endm1_in;
   logic [32:0]    skip_ff, skip_in;
   logic           ftaken_ff, ftaken_in;
   logic [31:0]    foff_ff, foff_in;
   logic           dtaken_ff, dtaken_in;
   logic [31:0]    doff_ff, doff_in;
   logic [31:0]    dlen_ff, dlen_in;
   logic           want_ff, want_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rwcl_rsp_type   rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        emit;
   logic [2:0]  emit_status;
   logic        chunk_done;
   logic [31:0] gather_shift;
   logic [32:0] pos_inc;
   logic [32:0] len_round;
   logic [33:0] reach;
   logic        past_end;
   logic        at_end;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign gather_shift = {req_data.file_byte, gather_ff[31:8]};
   assign pos_inc      = pos_ff + 33'd1;
   assign len_round    = {1'b0, gather_shift} + {32'd0, gather_shift[0]};
   // current position plus padded length, against end minus one
   assign reach        = {1'b0, pos_ff} + {2'b0, gather_shift} + {33'd0, gather_shift[0]};
   assign past_end     = reach >= {1'b0, endm1_ff};
   assign at_end       = pos_ff >= endm1_ff;

   always_comb begin
      want_in = (csr_valid && csr_ready) ? csr_data : want_ff;
   end

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      gather_in    = gather_ff;
      tag_in       = tag_ff;
      endm1_in     = endm1_ff;
      skip_in      = skip_ff;
      ftaken_in    = ftaken_ff;
      foff_in      = foff_ff;
      dtaken_in    = dtaken_ff;
      doff_in      = doff_ff;
      dlen_in      = dlen_ff;
      emit         = 1'b0;
      emit_status  = ST_NOT_FOUND;
      chunk_done   = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (req_fire) begin
         if (phase_ff != PH_DONE) begin
            pos_in = pos_inc;
         end
         unique case (phase_ff)
            PH_HEADER: begin
               gather_in = gather_shift;
               if (pos_ff == POS_RIFF_TAG && gather_shift != TAG_RIFF) begin
                  emit        = 1'b1;
                  emit_status = ST_NOT_RIFF;
               end
               if (pos_ff == POS_RIFF_LEN) begin
                  endm1_in = {1'b0, gather_shift} + 33'd7;
               end
               if (pos_ff == POS_WAVE_TAG) begin
                  if (gather_shift != TAG_WAVE) begin
                     emit        = 1'b1;
                     emit_status = ST_NOT_WAVE;
                  end else if (at_end) begin
                     emit        = 1'b1;
                     emit_status = ST_NOT_FOUND;
                  end else begin
                     phase_in = PH_TAG;
                     skip_in  = HDR_FIELD_LEN;
                  end
               end
            end
            PH_TAG: begin
               gather_in = gather_shift;
               skip_in   = skip_ff - 33'd1;
               if (skip_ff == 33'd1) begin
                  tag_in   = gather_shift;
                  phase_in = PH_LEN;
                  skip_in  = HDR_FIELD_LEN;
               end
            end
            PH_LEN: begin
               gather_in = gather_shift;
               skip_in   = skip_ff - 33'd1;
               if (skip_ff == 33'd1) begin
                  if (tag_ff == TAG_FMT) begin
                     if (want_ff && !ftaken_ff) begin
                        if (gather_shift < FMT_MIN_LEN) begin
                           emit        = 1'b1;
                           emit_status = ST_FMT_SHORT;
                           chunk_done  = 1'b1;
                        end else begin
                           ftaken_in = 1'b1;
                           foff_in   = pos_inc[31:0];
                           if (dtaken_ff && dlen_ff != 32'd0) begin
                              emit        = 1'b1;
                              emit_status = ST_OK;
                              chunk_done  = 1'b1;
                           end
                        end
                     end
                  end else if (tag_ff == TAG_DATA) begin
                     if (!dtaken_ff || dlen_ff == 32'd0) begin
                        dtaken_in = 1'b1;
                        doff_in   = pos_inc[31:0];
                        dlen_in   = gather_shift;
                        if (!want_ff || ftaken_ff) begin
                           emit        = 1'b1;
                           emit_status = ST_OK;
                           chunk_done  = 1'b1;
                        end
                     end
                  end
                  if (!chunk_done) begin
                     if (past_end) begin
                        emit        = 1'b1;
                        emit_status = ST_NOT_FOUND;
                     end else if (len_round == 33'd0) begin
                        phase_in = PH_TAG;
                        skip_in  = HDR_FIELD_LEN;
                     end else begin
                        phase_in = PH_SKIP;
                        skip_in  = len_round;
                     end
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 33'd1;
               if (skip_ff == 33'd1) begin
                  if (at_end) begin
                     emit        = 1'b1;
                     emit_status = ST_NOT_FOUND;
                  end else begin
                     phase_in = PH_TAG;
                     skip_in  = HDR_FIELD_LEN;
                  end
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase

         // early end of file before any decision
         if (req_data.last_byte && !emit && phase_ff != PH_DONE) begin
            emit        = 1'b1;
            emit_status = ST_NOT_FOUND;
         end

         if (emit) begin
            phase_in                  = PH_DONE;
            rsp_valid_in              = 1'b1;
            rsp_data_in.status        = emit_status;
            rsp_data_in.format_offset = foff_in;
            rsp_data_in.data_offset   = doff_in;
            rsp_data_in.data_length   = dlen_in;
         end

         if (req_data.last_byte) begin
            phase_in  = PH_HEADER;
            pos_in    = '0;
            gather_in = '0;
            tag_in    = '0;
            endm1_in  = '0;
            skip_in   = '0;
            ftaken_in = 1'b0;
            foff_in   = '0;
            dtaken_in = 1'b0;
            doff_in   = '0;
            dlen_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         gather_ff    <= '0;
         tag_ff       <= '0;
         endm1_ff     <= '0;
         skip_ff      <= '0;
         ftaken_ff    <= 1'b0;
         foff_ff      <= '0;
         dtaken_ff    <= 1'b0;
         doff_ff      <= '0;
         dlen_ff      <= '0;
         want_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         gather_ff    <= gather_in;
         tag_ff       <= tag_in;
         endm1_ff     <= endm1_in;
         skip_ff      <= skip_in;
         ftaken_ff    <= ftaken_in;
         foff_ff      <= foff_in;
         dtaken_ff    <= dtaken_in;
         doff_ff      <= doff_in;
         dlen_ff      <= dlen_in;
         want_ff      <= want_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`include "riff_wave_chunk_locator_unit_assert.svh"

   `RWCL_ASSERT_NOW(a_no_emit_when_blocked, clock, reset, emit, !(rsp_valid_ff && rsp_stall), "status word produced while output register is held")
   `RWCL_ASSERT_NEXT(a_last_clears, clock, reset, req_fire && req_data.last_byte, phase_ff == PH_HEADER && pos_ff == 33'd0 && !ftaken_ff && !dtaken_ff, "parse state not cleared after last byte")
   `RWCL_ASSERT_NOW(a_chunk_after_header, clock, reset, phase_ff == PH_TAG || phase_ff == PH_LEN || phase_ff == PH_SKIP, pos_ff >= POS_FIRST_CHK, "chunk phase before file header complete")
   `RWCL_ASSERT_NOW(a_hdr_count, clock, reset, phase_ff == PH_TAG || phase_ff == PH_LEN, skip_ff != 33'd0 && skip_ff <= HDR_FIELD_LEN, "header byte count out of range")
   `RWCL_ASSERT_NEXT(a_emit_to_done, clock, reset, emit && !req_data.last_byte, phase_ff == PH_DONE && rsp_valid_ff, "decision did not reach done phase and output")

endmodule
